@@ hw/rtl/hamming_31_26_decode_repack_top_assert.svh @@
// assertion macros for the hamming (31,26) decode and repack checker
// no dependencies; taken in by the checker file
`ifndef HAMMING_31_26_DECODE_REPACK_TOP_ASSERT_SVH
`define HAMMING_31_26_DECODE_REPACK_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define H3126_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define H3126_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/h3126_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and functions for the hamming (31,26) decode and repack block
// no dependencies
package h3126_pkg;

    localparam int CW_W    = 31;
    localparam int DATA_W  = 26;
    localparam int SYN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int LEFT_W  = 8;
    localparam int COUNT_W = 32;
    localparam int PACK_W  = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // codeword bits whose position number has syndrome bit j set
    localparam logic [CW_W-1:0] SYN_MASK0 = 31'h5555_5555;
    localparam logic [CW_W-1:0] SYN_MASK1 = 31'h6666_6666;
    localparam logic [CW_W-1:0] SYN_MASK2 = 31'h7878_7878;
    localparam logic [CW_W-1:0] SYN_MASK3 = 31'h7F80_7F80;
    localparam logic [CW_W-1:0] SYN_MASK4 = 31'h7FFF_8000;

    localparam logic [1:0] PHASE_LAST   = 2'd3;
    localparam logic [1:0] LAST_IDX_STD = 2'd2;
    localparam logic [1:0] LAST_IDX_BIG = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [PACK_W-1:0]  bits;      // packed stream, left aligned
        logic [1:0]         last_idx;  // index of the final byte
        logic               fixed;
        logic [COUNT_W-1:0] total;
    } t_entry;

    function automatic logic [SYN_W-1:0] syndrome(input logic [CW_W-1:0] cw);
        return {^(cw & SYN_MASK4), ^(cw & SYN_MASK3), ^(cw & SYN_MASK2),
                ^(cw & SYN_MASK1), ^(cw & SYN_MASK0)};
    endfunction

    function automatic logic [DATA_W-1:0] extract_data(input logic [CW_W-1:0] cw);
        return {cw[30:16], cw[14:8], cw[6:4], cw[2]};
    endfunction

endpackage

@@ hw/rtl/hamming_31_26_decode_repack_top.sv @@
`timescale 1ns / 1ps
// path: queue, then the back end's entry register, then the output register
// throughput: one byte per cycle while the byte side is ready and an entry waits,
//   three bytes per item, four on every fourth item (3.25 on average); the front
//   takes an item per cycle while the two-entry queue has room
// reset: synchronous, active low; clears phase, leftover bits, correction count,
//   queue pointers and output valid
// depends on h3126_pkg, h3126_front, h3126_fifo, h3126_back
module hamming_31_26_decode_repack_top
    import h3126_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items: one codeword each
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CW_W-1:0]    i_codeword,
    // output items: one repacked byte each
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_last_of_block,
    output logic               o_was_corrected,
    output logic [COUNT_W-1:0] o_corrections_total
);

    // front to queue
    logic   push;
    t_entry push_entry;
    logic   q_full;
    // queue to back
    logic   q_valid;
    logic   q_pop;
    t_entry q_entry;

    // syndrome, single-bit flip, data extraction and bit packing are all combinational;
    // phase, leftover bits and saturating count advance as the item is accepted
    h3126_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_codeword (i_codeword),
        .i_full     (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // decouples the front from a stalled output side
    h3126_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    // walks the packed word a byte at a time, most significant byte first;
    // the next entry is popped as the last byte loads, so bytes flow without gaps
    h3126_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_entry           (q_entry),
        .o_q_pop             (q_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_out_byte          (o_out_byte),
        .o_last_of_block     (o_last_of_block),
        .o_was_corrected     (o_was_corrected),
        .o_corrections_total (o_corrections_total)
    );

endmodule

@@ hw/rtl/h3126_front.sv @@
`timescale 1ns / 1ps
// front end: takes codewords, corrects, extracts data, packs with leftover bits
// depends on h3126_pkg
module h3126_front
    import h3126_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CW_W-1:0]   i_codeword,
    input  logic              i_full,
    output logic              o_push,
    output t_entry            o_entry
);

    logic [1:0]          r_phase,    n_phase;
    logic [LEFT_W-1:0]   r_leftover, n_leftover;
    logic [COUNT_W-1:0]  r_count,    n_count;

    logic [SYN_W-1:0]    syn;
    logic [CW_W-1:0]     flip;
    logic [CW_W-1:0]     fixed_cw;
    logic [DATA_W-1:0]   data;
    logic [LEFT_W+DATA_W-1:0] acc;
    logic [LEFT_W+DATA_W-1:0] aligned;
    logic [2:0]          shamt;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        syn      = syndrome(i_codeword);
        flip     = (syn != '0) ? (CW_W'(1) << (syn - SYN_W'(1))) : '0;
        fixed_cw = i_codeword ^ flip;
        data     = extract_data(fixed_cw);
        acc      = {r_leftover, data};
        // bring the top valid bit of the stream up to bit 31
        shamt    = 3'd6 - {r_phase, 1'b0};
        aligned  = acc << shamt;

        n_count  = r_count;
        if (syn != '0 && r_count != COUNT_MAX) begin
            n_count = r_count + COUNT_W'(1);
        end

        unique case (r_phase)
            2'd0:    n_leftover = {6'b0, data[1:0]};
            2'd1:    n_leftover = {4'b0, data[3:0]};
            2'd2:    n_leftover = {2'b0, data[5:0]};
            default: n_leftover = '0;
        endcase
        n_phase = r_phase + 2'd1;

        o_entry.bits     = aligned[PACK_W-1:0];
        o_entry.last_idx = (r_phase == PHASE_LAST) ? LAST_IDX_BIG : LAST_IDX_STD;
        o_entry.fixed    = (syn != '0);
        o_entry.total    = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_leftover <= '0;
            r_count    <= '0;
        end else if (o_push) begin
            r_phase    <= n_phase;
            r_leftover <= n_leftover;
            r_count    <= n_count;
        end
    end

endmodule

@@ hw/rtl/h3126_fifo.sv @@
`timescale 1ns / 1ps
// short register queue between front and back ends
// depends on h3126_pkg
module h3126_fifo
    import h3126_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_entry
);

    t_entry           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

endmodule

@@ hw/rtl/h3126_back.sv @@
`timescale 1ns / 1ps
// back end: splits queued entries into bytes behind an output register
// depends on h3126_pkg
module h3126_back
    import h3126_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_entry             i_q_entry,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_last_of_block,
    output logic               o_was_corrected,
    output logic [COUNT_W-1:0] o_corrections_total
);

    t_entry              r_cur;
    logic [1:0]          r_idx;
    logic                r_busy;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic                r_out_fixed;
    logic [COUNT_W-1:0]  r_out_total;

    logic                load;
    logic                is_last;
    logic [4:0]          shift;
    logic [BYTE_W-1:0]   sel_byte;

    always_comb begin
        load     = r_busy && (!r_out_valid || i_ready);
        is_last  = (r_idx == r_cur.last_idx);
        shift    = {2'd3 - r_idx, 3'b000};
        sel_byte = BYTE_W'(r_cur.bits >> shift);
        o_q_pop  = i_q_valid && (!r_busy || (load && is_last));
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_entry;
        end
        if (load) begin
            r_out_byte  <= sel_byte;
            r_out_last  <= is_last;
            r_out_fixed <= r_cur.fixed;
            r_out_total <= r_cur.total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (load && is_last) begin
                r_busy <= 1'b0;
            end else if (load) begin
                r_idx <= r_idx + 2'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_out_byte          = r_out_byte;
    assign o_last_of_block     = r_out_last;
    assign o_was_corrected     = r_out_fixed;
    assign o_corrections_total = r_out_total;

endmodule

@@ hw/rtl/h3126_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the hamming (31,26) decode and repack top level, with its bind
// depends on h3126_pkg and hamming_31_26_decode_repack_top_assert.svh
`include "hamming_31_26_decode_repack_top_assert.svh"

module h3126_checker
    import h3126_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [CW_W-1:0]    i_codeword,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [BYTE_W-1:0]  o_out_byte,
    input  logic               o_last_of_block,
    input  logic               o_was_corrected,
    input  logic [COUNT_W-1:0] o_corrections_total
);

    // a stalled output item stays
    `H3126_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte), "output item dropped or changed while stalled")

    // bytes of one codeword follow back to back with the same flags
    `H3126_ASSERT_NEXT(a_block_cont, i_clk, i_rst_n, o_valid && i_ready && !o_last_of_block, o_valid && o_was_corrected == $past(o_was_corrected) && o_corrections_total == $past(o_corrections_total), "codeword bytes not contiguous")

    // a corrected codeword has been counted
    `H3126_ASSERT_NOW(a_count_nz, i_clk, i_rst_n, o_valid && o_was_corrected, o_corrections_total != '0, "correction not counted")

    // no item on the output side straight out of reset
    `H3126_ASSERT_NEXT(a_reset_idle, i_clk, i_rst_n, $past(!i_rst_n), !o_valid, "output valid right after reset")

endmodule

bind hamming_31_26_decode_repack_top h3126_checker u_h3126_checker (.*);

@@ test/hamming_31_26_repack_checker.sv @@
`timescale 1ns / 1ps
// checker for the hamming (31,26) decode and repack block: watches both channels,
// predicts every repacked byte and compares it; depends on h3126_pkg for widths
module hamming_31_26_repack_checker
    import h3126_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [CW_W-1:0]    i_codeword,
    input  logic               i_valid_out,
    input  logic               i_ready,
    input  logic [BYTE_W-1:0]  i_out_byte,
    input  logic               i_last_of_block,
    input  logic               i_was_corrected,
    input  logic [COUNT_W-1:0] i_corrections_total,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic               last;
        logic               fixed;
        logic [COUNT_W-1:0] total;
    } t_repacked_byte;

    t_repacked_byte     expected_bytes[$];
    logic [1:0]         blk_phase;
    logic [LEFT_W-1:0]  carry_bits;
    logic [COUNT_W-1:0] fix_count;
    int                 fails;

    // decode one codeword, advance the repacking state and queue its bytes
    task automatic repack_codeword(input logic [CW_W-1:0] cw_in);
        logic [CW_W-1:0]    cw;
        logic [SYN_W-1:0]   syn;
        logic [DATA_W-1:0]  data;
        logic [DATA_W+7:0]  acc;
        logic               fixed;
        t_repacked_byte     entry;
        int                 k, d, nbits, nbytes, rem, pos;
        cw  = cw_in;
        syn = '0;
        for (k = 1; k <= CW_W; k++) begin
            if (cw[k-1])
                syn ^= 5'(k);
        end
        fixed = (syn != '0);
        if (fixed) begin
            pos = int'(syn) - 1;
            cw[pos] = ~cw[pos];
            if (fix_count != '1)
                fix_count = fix_count + 1;
        end
        // data bits sit at the positions that are not powers of two
        d = 0;
        for (k = 1; k <= CW_W; k++) begin
            if ((k & (k - 1)) != 0) begin
                data[d] = cw[k-1];
                d++;
            end
        end
        nbits  = DATA_W + 2 * int'(blk_phase);
        acc    = {carry_bits, data};
        nbytes = nbits / 8;
        for (k = 0; k < nbytes; k++) begin
            entry.value = acc[nbits - 8 * (k + 1) +: 8];
            entry.last  = (k + 1 == nbytes);
            entry.fixed = fixed;
            entry.total = fix_count;
            expected_bytes.push_back(entry);
        end
        rem        = nbits - 8 * nbytes;
        carry_bits = LEFT_W'(acc & ((34'd1 << rem) - 34'd1));
        blk_phase  = blk_phase + 2'd1;
    endtask

    always @(posedge i_clk) begin
        t_repacked_byte want;
        if (!i_rst_n) begin
            blk_phase  = '0;
            carry_bits = '0;
            fix_count  = '0;
            fails      = 0;
            expected_bytes.delete();
        end else begin
            if (i_valid && i_ready_in)
                repack_codeword(i_codeword);
            if (i_valid_out === 1'b1 && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: byte with none expected, expected none actual %02h",
                             $realtime, i_out_byte);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.value) begin
                        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                                 $realtime, want.value, i_out_byte);
                        fails++;
                    end
                    if (i_last_of_block !== want.last) begin
                        $display("%0t: last_of_block mismatch, expected %0b actual %0b",
                                 $realtime, want.last, i_last_of_block);
                        fails++;
                    end
                    if (i_was_corrected !== want.fixed) begin
                        $display("%0t: was_corrected mismatch, expected %0b actual %0b",
                                 $realtime, want.fixed, i_was_corrected);
                        fails++;
                    end
                    if (i_corrections_total !== want.total) begin
                        $display("%0t: corrections_total mismatch, expected %0d actual %0d",
                                 $realtime, want.total, i_corrections_total);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_bytes.size();
    end

endmodule

@@ test/tb_hamming_31_26_decode_repack_top.sv @@
`timescale 1ns / 1ps
// testbench top for the hamming (31,26) decode and repack block: drives codewords,
// throttles the byte side and gives the verdict; depends on h3126_pkg and the checker
module tb_hamming_31_26_decode_repack_top;
    import h3126_pkg::*;

    // cycles with no item moving on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 120;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [CW_W-1:0]    i_codeword;
    logic               o_valid;
    logic               i_ready;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_last_of_block;
    logic               o_was_corrected;
    logic [COUNT_W-1:0] o_corrections_total;

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    hamming_31_26_decode_repack_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_codeword          (i_codeword),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_out_byte          (o_out_byte),
        .o_last_of_block     (o_last_of_block),
        .o_was_corrected     (o_was_corrected),
        .o_corrections_total (o_corrections_total)
    );

    hamming_31_26_repack_checker i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .i_ready_in          (o_ready),
        .i_codeword          (i_codeword),
        .i_valid_out         (o_valid),
        .i_ready             (i_ready),
        .i_out_byte          (o_out_byte),
        .i_last_of_block     (o_last_of_block),
        .i_was_corrected     (o_was_corrected),
        .i_corrections_total (o_corrections_total),
        .o_fail_count        (fail_count),
        .o_outstanding       (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // byte side: stall at random at the current idle percentage
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: any accepted item on either side clears the count
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid === 1'b1 && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_hamming_31_26_decode_repack_top: FAIL");
            $finish;
        end
    end

    // build a clean codeword: data into the non power-of-two positions,
    // then set the parity bits that cancel the syndrome
    function automatic logic [CW_W-1:0] encode_data(input logic [DATA_W-1:0] data);
        logic [CW_W-1:0]  cw;
        logic [SYN_W-1:0] syn;
        int               k, d;
        cw  = '0;
        syn = '0;
        d   = 0;
        for (k = 1; k <= CW_W; k++) begin
            if ((k & (k - 1)) != 0) begin
                cw[k-1] = data[d];
                if (data[d])
                    syn ^= 5'(k);
                d++;
            end
        end
        for (k = 0; k < SYN_W; k++) begin
            if (syn[k])
                cw[(1 << k) - 1] = 1'b1;
        end
        return cw;
    endfunction

    // mostly clean and single-error words so the correction path gets exercised,
    // plus some double errors and raw noise
    function automatic logic [CW_W-1:0] random_codeword();
        logic [CW_W-1:0] cw;
        int              pick, b1, b2;
        cw   = encode_data(DATA_W'($urandom));
        pick = $urandom_range(0, 99);
        b1   = $urandom_range(0, CW_W - 1);
        b2   = (b1 + $urandom_range(1, CW_W - 1)) % CW_W;
        if (pick < 40) begin
            // clean word
        end else if (pick < 75) begin
            cw[b1] = ~cw[b1];
        end else if (pick < 88) begin
            cw[b1] = ~cw[b1];
            cw[b2] = ~cw[b2];
        end else begin
            cw = CW_W'($urandom);
        end
        return cw;
    endfunction

    // present one codeword; called just after the previous acceptance edge so
    // valid is either held high into the next item or dropped for a gap
    task automatic send_codeword(input logic [CW_W-1:0] cw);
        int  gap;
        logic take;
        gap = 0;
        while (gap < 200 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_codeword <= cw;
        // ready is settled by the falling edge, so sample it there
        do begin
            @(negedge i_clk);
            take = o_ready;
            @(posedge i_clk);
        end while (!take);
    endtask

    // sender stands still until every predicted byte has come out
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    initial begin
        logic [CW_W-1:0] base;
        int              ph, n;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_codeword    <= '0;
        send_idle_pct  = 29;
        recv_idle_pct  = 70;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, clean words, each parity position in error,
        // data positions at both ends, double and triple errors
        base = encode_data(26'h2F0_5A3C);
        send_codeword('0);
        send_codeword(31'h7FFF_FFFF);
        send_codeword(encode_data('1));
        send_codeword(encode_data(26'h2AA_AAAA));
        send_codeword(encode_data(26'h155_5555));
        send_codeword(base ^ 31'h0000_0001);
        send_codeword(base ^ 31'h0000_0002);
        send_codeword(base ^ 31'h0000_0008);
        send_codeword(base ^ 31'h0000_0080);
        send_codeword(base ^ 31'h0000_8000);
        send_codeword(base ^ 31'h0000_0004);
        send_codeword(base ^ 31'h4000_0000);
        send_codeword(base ^ 31'h0001_0000);
        send_codeword(base ^ 31'h0000_4000);
        // double error: miscorrected but still counted
        send_codeword(base ^ 31'h0000_0011);
        send_codeword(base ^ 31'h2000_0104);
        send_codeword(31'h7FFF_FFFF ^ 31'h4000_0000);
        send_codeword(31'h4000_0000);
        send_codeword(31'h0000_0001);
        send_codeword(encode_data('0) ^ 31'h0000_0100);

        // at least once the sender waits for the byte side to empty
        hold_until_drained();

        // random: three idle profiles, the last with no idling at all
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_codeword(random_codeword());
            hold_until_drained();
        end

        // let the clock run on after the drain to catch stray bytes
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_hamming_31_26_decode_repack_top: PASS");
        else
            $display("tb_hamming_31_26_decode_repack_top: FAIL");
        $finish;
    end

endmodule

@@ hamming_31_26_decode_repack_top.f @@
+incdir+hw/rtl
hw/rtl/h3126_pkg.sv
hw/rtl/h3126_front.sv
hw/rtl/h3126_fifo.sv
hw/rtl/h3126_back.sv
hw/rtl/hamming_31_26_decode_repack_top.sv
hw/rtl/h3126_checker.sv
test/hamming_31_26_repack_checker.sv
test/tb_hamming_31_26_decode_repack_top.sv
